// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL top level.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent on the same edge.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/bdde_pkg.sv -----
// Types and constants of the binary disk dilate/erode border block.
// No dependencies.
package bdde_pkg;

    localparam int DIM_W = 11;
    localparam int LIM_W = 7;
    localparam int IDX_W = 2;
    localparam int POS_W = 10;

    typedef enum logic [IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_LIMIT  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic in_group;
        logic is_flush;
    } in_t;

    typedef struct packed {
        logic             out_valid;
        logic [POS_W-1:0] out_x;
        logic [POS_W-1:0] out_y;
        logic             add_flag;
        logic             remove_flag;
        logic             frame_last;
    } out_t;

endpackage

// ----- rtl/bdde_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module bdde_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/binary_disk_dilate_erode_border.sv -----
// Top level: binary disk dilate/erode flags over a raster pixel stream.
// Depends on bdde_pkg, bdde_ram and assert_macros.svh.
//
//   channel | direction | handshake           | word
//   s_      | in        | s_valid / s_ready   | bdde_pkg::in_t
//   m_      | out       | m_valid / m_ready   | bdde_pkg::out_t
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One input word per cycle while s_ready is high; the line RAM is read one column
// ahead so each word passes through the window registers and then the flag logic.
// A result is held in the window stage, then in the output register, until taken.
// Synchronous active-low reset clears control state; line RAM is not cleared.
// A stalled output stops input only when both stages hold a result.
`include "assert_macros.svh"

module binary_disk_dilate_erode_border #(
    parameter int MAX_RADIUS = 8,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  bdde_pkg::in_t               s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output bdde_pkg::out_t              m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bdde_pkg::IDX_W-1:0]  cfg_index,
    input  logic [bdde_pkg::DIM_W-1:0]  cfg_data
);

    localparam int K  = 2 * MAX_RADIUS + 1;
    localparam int NT = 2 * MAX_RADIUS;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int HW = YW + 1;
    localparam int LW = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

    logic [bdde_pkg::DIM_W-1:0] width_reg, height_reg;
    logic [bdde_pkg::LIM_W-1:0] limit_reg;
    logic [WW-1:0] w_cl;
    logic [HW-1:0] h_cl;
    logic [LW-1:0] delay;
    int            lim_cl;

    logic [CW-1:0] in_col_reg, in_col_next;
    logic [HW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [YW-1:0] out_row_reg, out_row_next;
    logic [LW-1:0] lead_reg, lead_next;

    logic [K-1:0]  win_reg [K];
    logic [K-1:0]  col_vec;
    logic [NT-1:0] rd_word, ram_rd, wr_word_reg;

    logic          v1_reg, v1_next;
    logic [CW-1:0] ox1_reg;
    logic [YW-1:0] oy1_reg;
    logic          last1_reg;

    logic           m_valid_reg;
    bdde_pkg::out_t m_data_reg, res;

    logic accept, in_frame, adv, emit, is_last, s2_load, restart, cfg_restart;
    logic [WW-1:0] col_inc, ocol_inc;
    logic [CW-1:0] rd_addr;

    // dimension and limit clamps
    always_comb begin
        if (width_reg == '0) begin
            w_cl = WW'(1);
        end else if (int'(width_reg) > MAX_WIDTH) begin
            w_cl = WW'(MAX_WIDTH);
        end else begin
            w_cl = WW'(width_reg);
        end
        if (height_reg == '0) begin
            h_cl = HW'(1);
        end else if (int'(height_reg) > MAX_HEIGHT) begin
            h_cl = HW'(MAX_HEIGHT);
        end else begin
            h_cl = HW'(height_reg);
        end
        if (int'(limit_reg) > MAX_RADIUS * MAX_RADIUS) begin
            lim_cl = MAX_RADIUS * MAX_RADIUS;
        end else begin
            lim_cl = int'(limit_reg);
        end
        delay = LW'(MAX_RADIUS * int'(w_cl) + MAX_RADIUS);
    end

    assign cfg_ready = 1'b1;
    assign s2_load   = v1_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !v1_reg || s2_load;
    assign accept    = s_valid && s_ready;
    assign in_frame  = in_row_reg < h_cl;
    // drop a flush word while frame pixels are still expected
    assign adv       = accept && !(in_frame && s_data.is_flush);
    assign emit      = lead_reg == delay;
    assign is_last   = (WW'(out_col_reg) == w_cl - WW'(1))
                    && (HW'(out_row_reg) == h_cl - HW'(1));
    assign restart   = emit && is_last;
    assign col_inc   = WW'(in_col_reg) + WW'(1);
    assign ocol_inc  = WW'(out_col_reg) + WW'(1);
    // a width or height write restarts the frame
    assign cfg_restart = cfg_valid
                      && (cfg_index inside {bdde_pkg::REG_WIDTH, bdde_pkg::REG_HEIGHT});

    // stream and result position counters
    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        lead_next    = lead_reg;
        v1_next      = s2_load ? 1'b0 : v1_reg;
        if (adv) begin
            v1_next = emit;
            if (restart) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                lead_next    = '0;
            end else begin
                if (!emit) begin
                    lead_next = lead_reg + LW'(1);
                end
                if (col_inc == w_cl) begin
                    in_col_next = '0;
                    if (in_frame) begin
                        in_row_next = in_row_reg + HW'(1);
                    end
                end else begin
                    in_col_next = CW'(col_inc);
                end
                if (emit) begin
                    if (ocol_inc == w_cl) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + YW'(1);
                    end else begin
                        out_col_next = CW'(ocol_inc);
                    end
                end
            end
        end
        if (cfg_restart) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            lead_next    = '0;
        end
    end

    // line RAM: read the next column ahead, bypass for single-pixel rows
    assign rd_addr = in_col_next;
    assign rd_word = (w_cl == WW'(1)) ? wr_word_reg : ram_rd;
    assign col_vec = {rd_word, in_frame ? s_data.in_group : 1'b0};

    bdde_ram #(
        .WIDTH (NT),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (aclk),
        .wr_en   (adv),
        .wr_addr (in_col_reg),
        .wr_data (col_vec[NT-1:0]),
        .rd_en   (adv),
        .rd_addr (rd_addr),
        .rd_data (ram_rd)
    );

    // disk test over the window
    always_comb begin
        logic [K-1:0] col_ok, row_ok;
        logic         any_set, any_clear, centre;
        int           nx, ny, dx, dy;
        any_set   = 1'b0;
        any_clear = 1'b0;
        centre    = win_reg[MAX_RADIUS][MAX_RADIUS];
        for (int j = 0; j < K; j++) begin
            nx = int'(ox1_reg) + MAX_RADIUS - j;
            col_ok[j] = (nx >= 0) && (nx < int'(w_cl));
            ny = int'(oy1_reg) + MAX_RADIUS - j;
            row_ok[j] = (ny >= 0) && (ny < int'(h_cl));
        end
        for (int j = 0; j < K; j++) begin
            for (int k = 0; k < K; k++) begin
                dx = MAX_RADIUS - j;
                dy = MAX_RADIUS - k;
                if (col_ok[j] && row_ok[k] && (dx * dx + dy * dy <= lim_cl)) begin
                    if (win_reg[j][k]) begin
                        any_set = 1'b1;
                    end else begin
                        any_clear = 1'b1;
                    end
                end
            end
        end
        res.out_valid   = 1'b1;
        res.out_x       = bdde_pkg::POS_W'(ox1_reg);
        res.out_y       = bdde_pkg::POS_W'(oy1_reg);
        res.add_flag    = !centre && any_set;
        res.remove_flag = centre && any_clear;
        res.frame_last  = last1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= bdde_pkg::DIM_W'(1024);
            height_reg  <= bdde_pkg::DIM_W'(1024);
            limit_reg   <= bdde_pkg::LIM_W'(1);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            lead_reg    <= '0;
            v1_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int j = 0; j < K; j++) begin
                win_reg[j] <= '0;
            end
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            lead_reg    <= lead_next;
            v1_reg      <= v1_next;
            if (s2_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (adv) begin
                win_reg[0] <= col_vec;
                for (int j = 1; j < K; j++) begin
                    win_reg[j] <= win_reg[j-1];
                end
            end
            if (cfg_valid) begin
                case (bdde_pkg::reg_idx_t'(cfg_index))
                    bdde_pkg::REG_WIDTH: begin
                        width_reg <= cfg_data;
                    end
                    bdde_pkg::REG_HEIGHT: begin
                        height_reg <= cfg_data;
                    end
                    bdde_pkg::REG_LIMIT: begin
                        limit_reg <= cfg_data[bdde_pkg::LIM_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            wr_word_reg <= col_vec[NT-1:0];
            ox1_reg     <= out_col_reg;
            oy1_reg     <= out_row_reg;
            last1_reg   <= is_last;
        end
        if (s2_load) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_SAME(a_full_stall, aclk, aresetn, v1_reg && m_valid_reg && !m_ready, !s_ready)
    `ASSERT_SAME(a_col_range, aclk, aresetn, 1'b1, WW'(in_col_reg) < w_cl)
    `ASSERT_SAME(a_lead_range, aclk, aresetn, 1'b1, lead_reg <= delay)
    `ASSERT_NEXT(a_last_restart, aclk, aresetn, adv && restart,
                 lead_reg == '0 && out_col_reg == '0)

endmodule

// ----- dv/binary_disk_dilate_erode_border_test.sv -----
// Testbench for binary_disk_dilate_erode_border: random and directed frames of mask words,
// each result checked against a disk dilate/erode predictor kept in this file.
// Depends on bdde_pkg and the RTL top level.
`timescale 1ns / 100ps

module binary_disk_dilate_erode_border_test;

    localparam int RADIUS = 8;
    localparam int WIDTH_MAX = 1024;
    localparam int HEIGHT_MAX = 1024;
    localparam int ROWS_KEPT = 3 * RADIUS + 2;
    localparam int STALL_LIMIT = 5000;
    localparam int ITEM_TARGET = 1850;
    localparam logic [bdde_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

    logic aclk;
    logic aresetn;
    logic s_valid, s_ready, m_valid, m_ready, cfg_valid, cfg_ready;
    bdde_pkg::in_t s_data;
    bdde_pkg::out_t m_data;
    logic [bdde_pkg::IDX_W-1:0] cfg_index;
    logic [bdde_pkg::DIM_W-1:0] cfg_data;

    binary_disk_dilate_erode_border dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    bit mask_rows [ROWS_KEPT][WIDTH_MAX];
    int width_reg = 1024, height_reg = 1024, limit_reg = 1;
    int in_col, in_row, res_col, res_row;
    bdde_pkg::out_t flags_due[$];
    int errors;
    int sent;
    bit steady;
    int stall_cycles;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int clamp_dim(int v, int top);
        if (v < 1) return 1;
        if (v > top) return top;
        return v;
    endfunction

    function automatic int frame_w();
        return clamp_dim(width_reg, WIDTH_MAX);
    endfunction

    function automatic int frame_h();
        return clamp_dim(height_reg, HEIGHT_MAX);
    endfunction

    function automatic void restart_frame();
        in_col = 0;
        in_row = 0;
        res_col = 0;
        res_row = 0;
    endfunction

    function automatic void apply_reg(logic [bdde_pkg::IDX_W-1:0] idx,
                                      logic [bdde_pkg::DIM_W-1:0] val);
        case (idx)
            bdde_pkg::REG_WIDTH: begin
                width_reg = int'(val);
                restart_frame();
            end
            bdde_pkg::REG_HEIGHT: begin
                height_reg = int'(val);
                restart_frame();
            end
            bdde_pkg::REG_LIMIT: begin
                limit_reg = int'(val[bdde_pkg::LIM_W-1:0]);
            end
            default: ;
        endcase
    endfunction

    function automatic void advance_in(int w);
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
    endfunction

    // Disk flags for one accepted word; queue a result when one is due.
    function automatic void predict_flags(bdde_pkg::in_t word);
        int w, h, lim, lin, nx, ny;
        bit centre, nb, add, rem, last;
        bdde_pkg::out_t r;
        w = frame_w();
        h = frame_h();
        lim = (limit_reg > RADIUS * RADIUS) ? RADIUS * RADIUS : limit_reg;
        lin = in_row * w + in_col;
        if (lin < w * h) begin
            if (word.is_flush) return;
            mask_rows[in_row % ROWS_KEPT][in_col] = word.in_group;
        end
        if (lin < RADIUS * w + RADIUS) begin
            advance_in(w);
            return;
        end
        centre = mask_rows[res_row % ROWS_KEPT][res_col];
        add = 0;
        rem = 0;
        for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
            ny = res_row + dy;
            if (ny < 0 || ny >= h) continue;
            for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
                nx = res_col + dx;
                if (dx * dx + dy * dy > lim || nx < 0 || nx >= w) continue;
                nb = mask_rows[ny % ROWS_KEPT][nx];
                if (!centre && nb) add = 1;
                if (centre && !nb) rem = 1;
            end
        end
        last = (res_col == w - 1) && (res_row == h - 1);
        r.out_valid = 1'b1;
        r.out_x = res_col[bdde_pkg::POS_W-1:0];
        r.out_y = res_row[bdde_pkg::POS_W-1:0];
        r.add_flag = add;
        r.remove_flag = rem;
        r.frame_last = last;
        flags_due.push_back(r);
        if (last) begin
            restart_frame();
            return;
        end
        res_col++;
        if (res_col >= w) begin
            res_col = 0;
            res_row++;
        end
        advance_in(w);
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker
    always @(posedge aclk) begin
        bdde_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (flags_due.size() == 0) begin
                report("unexpected word", 1, 0);
            end else begin
                want = flags_due.pop_front();
                if (m_data.out_valid !== want.out_valid)
                    report("out_valid", int'(m_data.out_valid), int'(want.out_valid));
                if (m_data.out_x !== want.out_x)
                    report("out_x", int'(m_data.out_x), int'(want.out_x));
                if (m_data.out_y !== want.out_y)
                    report("out_y", int'(m_data.out_y), int'(want.out_y));
                if (m_data.add_flag !== want.add_flag)
                    report("add_flag", int'(m_data.add_flag), int'(want.add_flag));
                if (m_data.remove_flag !== want.remove_flag)
                    report("remove_flag", int'(m_data.remove_flag), int'(want.remove_flag));
                if (m_data.frame_last !== want.frame_last)
                    report("frame_last", int'(m_data.frame_last), int'(want.frame_last));
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        if (aresetn) m_ready <= steady || ($urandom_range(0, 99) >= 15);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL binary_disk_dilate_erode_border");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_word(bit group, bit flush);
        if (!steady && $urandom_range(0, 99) < 15) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data.in_group <= group;
        s_data.is_flush <= flush;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
        predict_flags('{in_group: group, is_flush: flush});
    endtask

    // Drop valid and hold until every pending result has drained.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (flags_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [bdde_pkg::IDX_W-1:0] idx,
                             logic [bdde_pkg::DIM_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        apply_reg(idx, val);
    endtask

    // One whole frame, with stray flush words mixed in, plus the trailing words that push out its last rows.
    task automatic run_frame(int density, int noise);
        int w, h;
        w = frame_w();
        h = frame_h();
        for (int p = 0; p < w * h; p++) begin
            if ($urandom_range(0, 99) < noise) send_word(1'($urandom_range(0, 1)), 1'b1);
            send_word($urandom_range(0, 99) < density, 1'b0);
        end
        for (int p = 0; p < RADIUS * w + RADIUS; p++)
            send_word(1'($urandom_range(0, 1)), $urandom_range(0, 99) < 100 - noise);
    endtask

    task automatic test_directed();
        write_reg(bdde_pkg::REG_WIDTH, 11'd4);
        write_reg(bdde_pkg::REG_HEIGHT, 11'd3);
        write_reg(bdde_pkg::REG_LIMIT, 11'd0);
        run_frame(50, 20);
        write_reg(bdde_pkg::REG_LIMIT, 11'd64);
        run_frame(30, 0);
        write_reg(bdde_pkg::REG_LIMIT, 11'd127);
        run_frame(70, 10);
        write_reg(REG_UNUSED, 11'h7ff);
        run_frame(100, 0);
        run_frame(0, 0);
        write_reg(bdde_pkg::REG_WIDTH, 11'd0);
        write_reg(bdde_pkg::REG_HEIGHT, 11'd0);
        run_frame(100, 50);
        // abandon a frame midway, then restart it with a width write
        write_reg(bdde_pkg::REG_WIDTH, 11'd3);
        write_reg(bdde_pkg::REG_HEIGHT, 11'd20);
        for (int p = 0; p < 40; p++) send_word(1'($urandom_range(0, 1)), 1'b0);
        write_reg(bdde_pkg::REG_WIDTH, 11'd3);
        write_reg(bdde_pkg::REG_HEIGHT, 11'd2);
        run_frame(50, 0);
    endtask

    // Oversized dimensions clamp; run partial frames and abandon them.
    task automatic test_extreme_sizes();
        write_reg(bdde_pkg::REG_WIDTH, 11'h7ff);
        write_reg(bdde_pkg::REG_HEIGHT, 11'd1);
        write_reg(bdde_pkg::REG_LIMIT, 11'd64);
        for (int p = 0; p < 30; p++) send_word($urandom_range(0, 99) < 10, 1'b0);
        write_reg(bdde_pkg::REG_WIDTH, 11'd1);
        write_reg(bdde_pkg::REG_HEIGHT, 11'h7ff);
        write_reg(bdde_pkg::REG_LIMIT, 11'd5);
        for (int p = 0; p < 60; p++) begin
            if ($urandom_range(0, 99) < 5) send_word(1'($urandom_range(0, 1)), 1'b1);
            send_word($urandom_range(0, 99) < 90, 1'b0);
        end
    endtask

    task automatic test_random_frames();
        int frames;
        frames = 0;
        while (sent < ITEM_TARGET) begin
            write_reg(bdde_pkg::REG_WIDTH, bdde_pkg::DIM_W'($urandom_range(1, 12)));
            write_reg(bdde_pkg::REG_HEIGHT, bdde_pkg::DIM_W'($urandom_range(1, 12)));
            write_reg(bdde_pkg::REG_LIMIT, bdde_pkg::DIM_W'($urandom_range(0, 127)));
            steady = (frames == 3);
            run_frame($urandom_range(0, 100), $urandom_range(0, 15));
            frames++;
        end
        steady = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = bdde_pkg::REG_WIDTH;
        cfg_data = '0;
        errors = 0;
        sent = 0;
        steady = 1'b0;
        restart_frame();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_extreme_sizes();
        test_random_frames();
        drain();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS binary_disk_dilate_erode_border");
        end else begin
            $display("FAIL binary_disk_dilate_erode_border");
        end
        $finish;
    end

endmodule
